FILE: rtl/core/acfb_pkg.sv
// Shared types and constants for the AT command frame builder.
`default_nettype none
package acfb_pkg;

    localparam int MAX_PARAMS = 4;

    localparam logic [7:0] TYPE_LOCAL      = 8'h08;
    localparam logic [7:0] TYPE_REMOTE     = 8'h17;
    localparam logic [7:0] ADDR_HIGH       = 8'hFF;
    localparam logic [7:0] ADDR_LOW        = 8'hFE;
    localparam logic [7:0] REMOTE_OPTION   = 8'h02;
    localparam logic [7:0] LOCAL_BASE_LEN  = 8'd4;
    localparam logic [7:0] REMOTE_BASE_LEN = 8'd15;
    localparam logic [7:0] START_DELIM_RST = 8'h7E;

    // One classified request, ready for serialization.
    typedef struct packed {
        logic        kind;
        logic [7:0]  seq_id;
        logic [7:0]  len;
        logic [31:0] dest_high;
        logic [31:0] dest_low;
        logic [7:0]  cmd_first;
        logic [7:0]  cmd_second;
        logic [2:0]  param_count;
        logic [7:0]  param0;
        logic [7:0]  param1;
        logic [7:0]  param2;
        logic [7:0]  param3;
    } t_req;

    // Handshake between the request queue and the serializer.
    typedef struct packed {
        logic valid;
        t_req req;
    } t_req_chan;

endpackage
`default_nettype wire

FILE: rtl/core/at_command_frame_builder.sv
// Top level of the AT command frame builder.
//
// Input channel (push/full): one AT command request per transfer, local or
// remote, with command characters and up to four parameter bytes. A
// transfer happens on a rising edge with push high and full low.
// Output channel (empty/pop): one frame byte per transfer; o_last marks the
// checksum byte that closes a frame. The head byte is valid while empty is
// low and leaves on an edge with pop high.
// Configuration: i_cfg_we/i_cfg_data load the start delimiter; write only
// while no frame is in flight.
// Throughput: one byte per cycle while the receiver pops; a frame is 8 + params
// bytes (local) or 19 + params (remote), at most 23. The byte sequencer starts
// the next frame right after the checksum. A request passes the queue and the
// serializer's request register; its first byte then fills the output register.
// A two-entry request queue lets requests be taken while a frame is still
// being sent; full rises when it holds two waiting requests.
// When the receiver stalls, the output register holds its byte and the
// serializer stops; the queue then fills and full goes high.
// Reset: clears the frame ID counter, queue and serializer and restores
// the start delimiter to 0x7E.
`default_nettype none
module at_command_frame_builder import acfb_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_data,
    input  wire         push,
    output logic        full,
    input  wire         i_kind,
    input  wire         i_wants_ack,
    input  wire  [31:0] i_dest_high,
    input  wire  [31:0] i_dest_low,
    input  wire  [7:0]  i_cmd_first,
    input  wire  [7:0]  i_cmd_second,
    input  wire  [2:0]  i_param_count,
    input  wire  [7:0]  i_param0,
    input  wire  [7:0]  i_param1,
    input  wire  [7:0]  i_param2,
    input  wire  [7:0]  i_param3,
    output logic        empty,
    input  wire         pop,
    output logic [7:0]  o_frame_byte,
    output logic        o_last
);

    logic [7:0] r_start_delimiter;
    logic       w_accept;
    logic       w_q_full;
    logic       w_q_pop;
    t_req       w_req;
    t_req_chan  w_head;

    // Hold the start delimiter; reload on each configuration write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delimiter <= START_DELIM_RST;
        end else if (i_cfg_we) begin
            r_start_delimiter <= i_cfg_data;
        end
    end

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    // Classify the request and assign its frame ID.
    acfb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_kind        (i_kind),
        .i_wants_ack   (i_wants_ack),
        .i_dest_high   (i_dest_high),
        .i_dest_low    (i_dest_low),
        .i_cmd_first   (i_cmd_first),
        .i_cmd_second  (i_cmd_second),
        .i_param_count (i_param_count),
        .i_param0      (i_param0),
        .i_param1      (i_param1),
        .i_param2      (i_param2),
        .i_param3      (i_param3),
        .o_req         (w_req)
    );

    // Buffer classified requests so front and back stall independently.
    acfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_req   (w_req),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_head  (w_head)
    );

    // Serialize one frame byte per cycle while the receiver pops, and append the checksum.
    acfb_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start_delimiter (r_start_delimiter),
        .i_head            (w_head),
        .o_take            (w_q_pop),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_frame_byte      (o_frame_byte),
        .o_last            (o_last)
    );

    // The serializer only takes a request that the queue holds.
    a_take_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_head.valid)
        else $error("serializer took a request from an empty queue");

    // A local request always carries a nonzero frame ID.
    a_local_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_kind) |-> (w_req.seq_id != 8'd0))
        else $error("local request got frame ID zero");

    // A remote request that asks for no acknowledgement gets frame ID zero and leaves the ID counter alone.
    a_no_ack_keeps_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind && !i_wants_ack) |-> (w_req.seq_id == 8'd0))
        else $error("remote request without acknowledgement got a frame ID");

endmodule
`default_nettype wire

FILE: rtl/core/acfb_front.sv
// Request classifier: frame ID assignment, count saturation, length.
`default_nettype none
module acfb_front import acfb_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_accept,
    input  wire         i_kind,
    input  wire         i_wants_ack,
    input  wire  [31:0] i_dest_high,
    input  wire  [31:0] i_dest_low,
    input  wire  [7:0]  i_cmd_first,
    input  wire  [7:0]  i_cmd_second,
    input  wire  [2:0]  i_param_count,
    input  wire  [7:0]  i_param0,
    input  wire  [7:0]  i_param1,
    input  wire  [7:0]  i_param2,
    input  wire  [7:0]  i_param3,
    output t_req        o_req
);

    logic [7:0] r_seq_id;
    logic [7:0] n_seq_id;
    logic       w_take_id;
    logic [7:0] w_inc;
    logic [2:0] w_count;

    assign w_take_id = !i_kind || i_wants_ack;
    assign w_inc     = r_seq_id + 8'd1;
    // Skip zero on wrap.
    assign n_seq_id  = (w_inc == 8'd0) ? 8'd1 : w_inc;
    assign w_count   = (i_param_count > 3'(MAX_PARAMS)) ? 3'(MAX_PARAMS) : i_param_count;

    always_comb begin
        o_req.kind        = i_kind;
        o_req.seq_id      = w_take_id ? n_seq_id : 8'd0;
        o_req.len         = (i_kind ? REMOTE_BASE_LEN : LOCAL_BASE_LEN) + {5'd0, w_count};
        o_req.dest_high   = i_dest_high;
        o_req.dest_low    = i_dest_low;
        o_req.cmd_first   = i_cmd_first;
        o_req.cmd_second  = i_cmd_second;
        o_req.param_count = w_count;
        o_req.param0      = i_param0;
        o_req.param1      = i_param1;
        o_req.param2      = i_param2;
        o_req.param3      = i_param3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_id <= 8'd0;
        end else if (i_accept && w_take_id) begin
            r_seq_id <= n_seq_id;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/acfb_queue.sv
// Two-entry request queue between classifier and serializer.
`default_nettype none
module acfb_queue import acfb_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  wire t_req  i_req,
    output logic       o_full,
    input  wire        i_pop,
    output t_req_chan  o_head
);

    t_req       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full       = (r_cnt == 2'd2);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.req   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/acfb_back.sv
// Frame serializer: byte sequencer, checksum and output register.
`default_nettype none
module acfb_back import acfb_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire  [7:0] i_start_delimiter,
    input  wire t_req_chan i_head,
    output logic       o_take,
    output logic       o_empty,
    input  wire        i_pop,
    output logic [7:0] o_frame_byte,
    output logic       o_last
);

    localparam logic [4:0] POS_DELIM  = 5'd0;
    localparam logic [4:0] POS_LEN_HI = 5'd1;
    localparam logic [4:0] POS_LEN_LO = 5'd2;
    localparam logic [4:0] POS_TYPE   = 5'd3;
    localparam logic [4:0] POS_ID     = 5'd4;
    localparam logic [4:0] POS_DH0    = 5'd5;
    localparam logic [4:0] POS_DH1    = 5'd6;
    localparam logic [4:0] POS_DH2    = 5'd7;
    localparam logic [4:0] POS_DH3    = 5'd8;
    localparam logic [4:0] POS_DL0    = 5'd9;
    localparam logic [4:0] POS_DL1    = 5'd10;
    localparam logic [4:0] POS_DL2    = 5'd11;
    localparam logic [4:0] POS_DL3    = 5'd12;
    localparam logic [4:0] POS_ADDR_H = 5'd13;
    localparam logic [4:0] POS_ADDR_L = 5'd14;
    localparam logic [4:0] POS_OPT    = 5'd15;
    localparam logic [4:0] POS_CMD0   = 5'd16;
    localparam logic [4:0] POS_CMD1   = 5'd17;
    localparam logic [4:0] POS_PAR0   = 5'd18;
    localparam logic [4:0] POS_PAR1   = 5'd19;
    localparam logic [4:0] POS_PAR2   = 5'd20;
    localparam logic [4:0] POS_PAR3   = 5'd21;

    t_req       r_req;
    logic       r_busy;
    logic [4:0] r_pos;
    logic [4:0] n_pos;
    logic [7:0] r_sum;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic [7:0] w_data;
    logic       w_is_last;
    logic       w_adv;

    assign w_is_last = (r_pos == (POS_PAR0 + {2'd0, r_req.param_count}));
    assign w_adv     = r_busy && (!r_out_valid || i_pop);
    assign o_take    = i_head.valid && (!r_busy || (w_adv && w_is_last));
    // Local frames jump over the remote addressing bytes.
    assign n_pos     = (r_pos == POS_ID && !r_req.kind) ? POS_CMD0 : r_pos + 5'd1;

    always_comb begin
        case (r_pos)
            POS_DELIM:  w_data = i_start_delimiter;
            POS_LEN_HI: w_data = 8'd0;
            POS_LEN_LO: w_data = r_req.len;
            POS_TYPE:   w_data = r_req.kind ? TYPE_REMOTE : TYPE_LOCAL;
            POS_ID:     w_data = r_req.seq_id;
            POS_DH0:    w_data = r_req.dest_high[31:24];
            POS_DH1:    w_data = r_req.dest_high[23:16];
            POS_DH2:    w_data = r_req.dest_high[15:8];
            POS_DH3:    w_data = r_req.dest_high[7:0];
            POS_DL0:    w_data = r_req.dest_low[31:24];
            POS_DL1:    w_data = r_req.dest_low[23:16];
            POS_DL2:    w_data = r_req.dest_low[15:8];
            POS_DL3:    w_data = r_req.dest_low[7:0];
            POS_ADDR_H: w_data = ADDR_HIGH;
            POS_ADDR_L: w_data = ADDR_LOW;
            POS_OPT:    w_data = REMOTE_OPTION;
            POS_CMD0:   w_data = r_req.cmd_first;
            POS_CMD1:   w_data = r_req.cmd_second;
            POS_PAR0:   w_data = r_req.param0;
            POS_PAR1:   w_data = r_req.param1;
            POS_PAR2:   w_data = r_req.param2;
            POS_PAR3:   w_data = r_req.param3;
            default:    w_data = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_req <= i_head.req;
        end
        if (o_take) begin
            r_sum <= 8'd0;
        end else if (w_adv && r_pos >= POS_TYPE) begin
            r_sum <= r_sum + w_data;
        end
        if (o_take) begin
            r_pos <= POS_DELIM;
        end else if (w_adv) begin
            r_pos <= n_pos;
        end
        if (w_adv) begin
            r_out_byte <= w_is_last ? ~r_sum : w_data;
            r_out_last <= w_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_busy <= 1'b1;
            end else if (w_adv && w_is_last) begin
                r_busy <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last       = r_out_last;

endmodule
`default_nettype wire
